[hw/rtl/sr_pkg.sv]
// sr_pkg: shared types, widths, codes and constant helpers of the synaptic rectifier.
// Used by sr_front, sr_queue, sr_back and synaptic_rectifier; depends on nothing.
`timescale 1ns / 1ps
package sr_pkg;

	// Fixed formats
	localparam int SAMPLE_W      = 32;
	localparam int FRAC_BITS     = 16;
	localparam int LOG_EXP_STEPS = 20;
	localparam int GAIN_W        = 32;
	localparam int GMAX_W        = 40;
	localparam int ETA_W         = 16;
	localparam int OFFSET_W      = 32;
	localparam int EXP_W         = 24;
	localparam int COND_W        = 48;
	localparam int CFG_DATA_W    = 40;
	localparam int CFG_IDX_W     = 3;

	// Internal widths
	localparam int DIFF_W  = SAMPLE_W + 1;            // sample minus offset
	localparam int LEAD_W  = $clog2(DIFF_W);          // leading-one position
	localparam int MANT_W  = 31;                      // Q1.30 log mantissa
	localparam int NORM_W  = DIFF_W + MANT_W - 1;
	localparam int SQ_W    = 2 * MANT_W;
	localparam int LG_W    = LEAD_W + 1 + LOG_EXP_STEPS;
	localparam int Y_W     = LG_W + EXP_W + 1;
	localparam int TB      = LOG_EXP_STEPS + FRAC_BITS;
	localparam int YI_W    = Y_W - TB;
	localparam int R_W     = 32;                      // Q1.31 exp accumulator
	localparam int RP_W    = 2 * R_W;
	localparam int PMAG_W  = 61;                      // clipped power / work point
	localparam int PLO_W   = 31;                      // low split of pmag
	localparam int PLOP_W  = GAIN_W + PLO_W;
	localparam int PHIP_W  = GAIN_W + PMAG_W - PLO_W;
	localparam int P_W     = GAIN_W + PMAG_W;
	localparam int LINP_W  = 2 * SAMPLE_W;
	localparam int DEN_W   = PMAG_W + 1;
	localparam int T_W     = FRAC_BITS + 1;
	localparam int GP_W    = 2 * T_W;
	localparam int CP_W    = GMAX_W + T_W;
	localparam int POW_BIAS      = 31 - FRAC_BITS;
	localparam int POW_SAT_SHIFT = 30;

	localparam logic [PMAG_W-1:0] MAG_LIMIT = {PMAG_W{1'b1}};
	localparam logic [T_W-1:0]    ONE       = T_W'(1) << FRAC_BITS;
	localparam logic [R_W-1:0]    R_ONE     = R_W'(1) << (R_W - 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Back pipeline stage map
	localparam int ST_A      = 0;
	localparam int ST_B      = 1;
	localparam int ST_LOG0   = 2;
	localparam int ST_Y      = ST_LOG0 + LOG_EXP_STEPS;
	localparam int ST_SPLIT  = ST_Y + 1;
	localparam int ST_EXP0   = ST_SPLIT + 1;
	localparam int ST_SHIFT  = ST_EXP0 + LOG_EXP_STEPS;
	localparam int ST_MUL0   = ST_SHIFT + 1;
	localparam int ST_MUL1   = ST_MUL0 + 1;
	localparam int ST_SUM    = ST_MUL1 + 1;
	localparam int ST_OVF    = ST_SUM + 1;
	localparam int ST_DIV0   = ST_OVF + 1;
	localparam int ST_WSEL   = ST_DIV0 + PMAG_W;
	localparam int ST_FSET   = ST_WSEL + 1;
	localparam int ST_F0     = ST_FSET + 1;
	localparam int ST_FSTEP0 = ST_F0 + 1;
	localparam int ST_G      = ST_FSTEP0 + FRAC_BITS;
	localparam int ST_OUT    = ST_G + 1;
	localparam int NSTAGE    = ST_OUT + 1;

	// Mode codes
	localparam logic [1:0] MODE_BYPASS = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_NONLIN = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GMAX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 3'd5;

	typedef enum logic [1:0] {
		KIND_BYPASS,
		KIND_LINEAR,
		KIND_NONLIN
	} kind_t;

	typedef struct packed {
		logic [1:0]                 mode;
		logic signed [GAIN_W-1:0]   gain;
		logic [GMAX_W-1:0]          max_cond;
		logic [ETA_W-1:0]           leak;
		logic signed [OFFSET_W-1:0] offset;
		logic [EXP_W-1:0]           exponent;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		kind_t                      kind;
		logic signed [SAMPLE_W-1:0] smp;
		logic [DIFF_W-1:0]          m;
		logic                       pneg;
		logic                       skip;
		logic                       m_zero;
		logic                       e_zero;
	} item_t;

	// Everything one item carries through the back pipeline
	typedef struct packed {
		kind_t                      kind;
		logic signed [SAMPLE_W-1:0] smp;
		logic [GAIN_W-1:0]          gmag;
		logic                       gneg;
		logic [LINP_W-1:0]          lin_p;
		logic                       lin_neg;
		logic [COND_W-1:0]          res;
		logic                       sat;
		logic                       pneg;
		logic                       skip;
		logic                       m_zero;
		logic                       e_zero;
		logic [DIFF_W-1:0]          m;
		logic [LEAD_W-1:0]          n;
		logic [MANT_W-1:0]          x;
		logic [LOG_EXP_STEPS-1:0]   lfrac;
		logic signed [Y_W-1:0]      y;
		logic signed [YI_W-1:0]     yi;
		logic [LOG_EXP_STEPS-1:0]   fb;
		logic [R_W-1:0]             r;
		logic [PMAG_W-1:0]          pmag;
		logic [PLOP_W-1:0]          plo;
		logic [PHIP_W-1:0]          phi;
		logic [P_W-1:0]             p;
		logic                       ovf;
		logic [GMAX_W-1:0]          rem;
		logic [PMAG_W-1:0]          q;
		logic                       wneg;
		logic                       pos;
		logic [PMAG_W-1:0]          wmag;
		logic [DEN_W-1:0]           fr;
		logic [DEN_W-1:0]           den;
		logic [T_W-1:0]             t;
		logic [T_W-1:0]             gv;
	} work_t;

	// Integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bit_v;
		v     = v_in;
		res   = '0;
		bit_v = 64'h4000_0000_0000_0000;
		for (int k = 0; k < 32; k++) begin
			if (v >= res + bit_v) begin
				v   = v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.31, each factor the root of the one before, from 2.0
	function automatic logic [R_W-1:0] exp_factor(input int k);
		logic [63:0] c;
		c = 64'h1_0000_0000;
		for (int j = 1; j <= k; j++) begin
			c = isqrt64(c << 31);
		end
		return c[R_W-1:0];
	endfunction

endpackage

[hw/rtl/synaptic_rectifier.sv]
// synaptic_rectifier: a sample passes the input register, the queue and all stages of the 131-stage
// back pipeline, up to its output register, before its result is valid.
// Throughput one sample per cycle while the result is taken; the depth is set by the one-bit-per-stage Gmax divider
// and the per-stage log2 squarings and exp2 factors.
// Reset clears all valids and the queue and loads the register defaults
// (bypass, gain 1.0, Gmax 50000.0, no leak, offset 0, exponent 1.0).
// Depends on sr_pkg, sr_front, sr_queue, sr_back.
`timescale 1ns / 1ps
module synaptic_rectifier (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [sr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sr_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic signed [sr_pkg::SAMPLE_W-1:0]   sample,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [sr_pkg::COND_W-1:0]     conductance,
	output logic                                 saturated
);

	sr_pkg::cfg_t  cfg_q;
	sr_pkg::item_t front_item;
	sr_pkg::item_t back_item;
	logic          front_valid;
	logic          front_ready;
	logic          back_valid;
	logic          back_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= sr_pkg::MODE_BYPASS;
			cfg_q.gain     <= sr_pkg::GAIN_W'(sr_pkg::ONE);
			cfg_q.max_cond <= sr_pkg::GMAX_W'(40'd50000 << sr_pkg::FRAC_BITS);
			cfg_q.leak     <= '0;
			cfg_q.offset   <= '0;
			cfg_q.exponent <= sr_pkg::EXP_W'(sr_pkg::ONE);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				sr_pkg::REG_MODE:     cfg_q.mode     <= cfg_data[1:0];
				sr_pkg::REG_GAIN:     cfg_q.gain     <= cfg_data[sr_pkg::GAIN_W-1:0];
				sr_pkg::REG_GMAX:     cfg_q.max_cond <= cfg_data[sr_pkg::GMAX_W-1:0];
				sr_pkg::REG_LEAK:     cfg_q.leak     <= cfg_data[sr_pkg::ETA_W-1:0];
				sr_pkg::REG_OFFSET:   cfg_q.offset   <= cfg_data[sr_pkg::OFFSET_W-1:0];
				sr_pkg::REG_EXPONENT: cfg_q.exponent <= cfg_data[sr_pkg::EXP_W-1:0];
				default: ;
			endcase
		end
	end

	sr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.item_valid   (front_valid),
		.item_ready   (front_ready),
		.item         (front_item)
	);

	sr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_item)
	);

	sr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (back_valid),
		.item_ready   (back_ready),
		.item         (back_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.conductance  (conductance),
		.saturated    (saturated)
	);

endmodule

[hw/rtl/sr_queue.sv]
// sr_queue: short FIFO of classified items between front and back.
// Depends on sr_pkg (item_t, queue depth).
`timescale 1ns / 1ps
module sr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  sr_pkg::item_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output sr_pkg::item_t pop_data
);

	sr_pkg::item_t                mem_q [sr_pkg::QUEUE_DEPTH];
	logic [sr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sr_pkg::QPTR_W:0]      count_q;
	logic                         push;
	logic                         pop;

	assign push_ready = (count_q != (sr_pkg::QPTR_W + 1)'(sr_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

[hw/rtl/sr_front.sv]
// sr_front: accepts samples, subtracts the offset and classifies each transaction.
// Depends on sr_pkg (cfg_t, item_t, mode codes).
`timescale 1ns / 1ps
module sr_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sr_pkg::cfg_t                       cfg,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  logic signed [sr_pkg::SAMPLE_W-1:0] sample,
	output logic                               item_valid,
	input  logic                               item_ready,
	output sr_pkg::item_t                      item
);

	sr_pkg::item_t                     item_s1;
	logic                              vld_s1;
	sr_pkg::item_t                     cls;
	logic signed [sr_pkg::DIFF_W-1:0]  d;

	// classification
	always_comb begin
		d = sr_pkg::DIFF_W'(sample) - sr_pkg::DIFF_W'(cfg.offset);
		cls.smp    = sample;
		cls.m      = d[sr_pkg::DIFF_W-1] ? (~d + 1'b1) : d;
		cls.m_zero = (d == '0);
		cls.skip   = (cfg.exponent == sr_pkg::EXP_W'(sr_pkg::ONE));
		cls.e_zero = (cfg.exponent == '0);
		cls.pneg   = cls.skip ? d[sr_pkg::DIFF_W-1] : (d[sr_pkg::DIFF_W-1] || cls.m_zero);
		unique case (cfg.mode)
			sr_pkg::MODE_LINEAR: cls.kind = sr_pkg::KIND_LINEAR;
			sr_pkg::MODE_NONLIN: cls.kind = sr_pkg::KIND_NONLIN;
			default:             cls.kind = sr_pkg::KIND_BYPASS;
		endcase
	end

	assign sample_ready = !vld_s1 || item_ready;
	assign item_valid   = vld_s1;
	assign item         = item_s1;

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample_ready) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) item_s1 <= cls;
	end

endmodule

[hw/rtl/sr_back.sv]
// sr_back: pipelined transfer function: linear product, log2/exp2 power,
// work point division, rectifier fraction and final scaling. Last stage is the output register.
// Depends on sr_pkg (work_t, stage map, widths, exp_factor).
`timescale 1ns / 1ps
module sr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sr_pkg::cfg_t                     cfg,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  sr_pkg::item_t                    item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic signed [sr_pkg::COND_W-1:0] conductance,
	output logic                             saturated
);

	sr_pkg::work_t                 pipe_s [sr_pkg::NSTAGE];
	sr_pkg::work_t                 nxt    [sr_pkg::NSTAGE];
	logic [sr_pkg::NSTAGE-1:0]     vld_s;
	logic                          en;
	logic [sr_pkg::R_W-1:0]        fac [sr_pkg::LOG_EXP_STEPS];

	// exp2 factors, worked out at elaboration
	for (genvar g = 0; g < sr_pkg::LOG_EXP_STEPS; g++) begin : g_fac
		localparam logic [sr_pkg::R_W-1:0] C = sr_pkg::exp_factor(g + 1);
		assign fac[g] = C;
	end

	// whole pipeline moves unless the output register holds an untaken result
	assign en           = !vld_s[sr_pkg::NSTAGE-1] || result_ready;
	assign item_ready   = en;
	assign result_valid = vld_s[sr_pkg::NSTAGE-1];
	assign conductance  = pipe_s[sr_pkg::ST_OUT].res;
	assign saturated    = pipe_s[sr_pkg::ST_OUT].sat;

	always_comb begin
		sr_pkg::work_t                    w;
		logic [sr_pkg::GAIN_W-1:0]        smag;
		logic [sr_pkg::NORM_W-1:0]        norm;
		logic [sr_pkg::COND_W-1:0]        linv;
		logic [sr_pkg::SQ_W-1:0]          sq;
		logic [sr_pkg::MANT_W:0]          xs;
		logic signed [sr_pkg::LEAD_W:0]   lead_s;
		logic signed [sr_pkg::LG_W-1:0]   lg;
		logic [sr_pkg::RP_W-1:0]          rp;
		logic signed [sr_pkg::YI_W:0]     s;
		logic [sr_pkg::YI_W:0]            rsh;
		logic [sr_pkg::PMAG_W-1:0]        pw;
		logic                             psat;
		logic [sr_pkg::GMAX_W:0]          trial;
		logic [sr_pkg::DEN_W:0]           fr2;
		logic [sr_pkg::T_W-1:0]           eta;
		logic [sr_pkg::GP_W-1:0]          gp;
		logic [sr_pkg::CP_W-1:0]          cp;

		eta = sr_pkg::T_W'(cfg.leak);

		// magnitudes, linear product, leading one
		w        = '0;
		w.kind   = item.kind;
		w.smp    = item.smp;
		w.m      = item.m;
		w.pneg   = item.pneg;
		w.skip   = item.skip;
		w.m_zero = item.m_zero;
		w.e_zero = item.e_zero;
		w.gneg   = cfg.gain[sr_pkg::GAIN_W-1];
		w.gmag   = w.gneg ? (~cfg.gain + 1'b1) : cfg.gain;
		smag     = item.smp[sr_pkg::SAMPLE_W-1] ? (~item.smp + 1'b1) : item.smp;
		w.lin_neg = item.smp[sr_pkg::SAMPLE_W-1] ^ w.gneg;
		w.lin_p   = sr_pkg::LINP_W'(w.gmag) * sr_pkg::LINP_W'(smag);
		for (int i = 0; i < sr_pkg::DIFF_W; i++) begin
			if (item.m[i]) w.n = sr_pkg::LEAD_W'(i);
		end
		nxt[sr_pkg::ST_A] = w;

		// normalize mantissa, bypass and linear results
		w      = pipe_s[sr_pkg::ST_A];
		norm   = {w.m, {(sr_pkg::MANT_W - 1){1'b0}}} >> w.n;
		w.x    = norm[sr_pkg::MANT_W-1:0];
		w.lfrac = '0;
		linv   = sr_pkg::COND_W'(w.lin_p[sr_pkg::LINP_W-2:sr_pkg::FRAC_BITS]);
		w.sat  = 1'b0;
		if (w.kind == sr_pkg::KIND_LINEAR) w.res = w.lin_neg ? (~linv + 1'b1) : linv;
		else w.res = sr_pkg::COND_W'(w.smp);
		nxt[sr_pkg::ST_B] = w;

		// log2 fraction: one squaring per stage
		for (int i = 0; i < sr_pkg::LOG_EXP_STEPS; i++) begin
			w  = pipe_s[sr_pkg::ST_LOG0 + i - 1];
			sq = sr_pkg::SQ_W'(w.x) * sr_pkg::SQ_W'(w.x);
			xs = sq[sr_pkg::SQ_W-1:sr_pkg::MANT_W-1];
			w.lfrac = {w.lfrac[sr_pkg::LOG_EXP_STEPS-2:0], xs[sr_pkg::MANT_W]};
			w.x = xs[sr_pkg::MANT_W] ? xs[sr_pkg::MANT_W:1] : xs[sr_pkg::MANT_W-1:0];
			nxt[sr_pkg::ST_LOG0 + i] = w;
		end

		// log times exponent
		w      = pipe_s[sr_pkg::ST_Y - 1];
		lead_s = $signed({1'b0, w.n}) - (sr_pkg::LEAD_W + 1)'(sr_pkg::FRAC_BITS);
		lg     = $signed({lead_s, w.lfrac});
		w.y    = sr_pkg::Y_W'(lg) * sr_pkg::Y_W'($signed({1'b0, cfg.exponent}));
		nxt[sr_pkg::ST_Y] = w;

		// floor split into integer and fraction
		w      = pipe_s[sr_pkg::ST_SPLIT - 1];
		w.yi   = w.y[sr_pkg::Y_W-1:sr_pkg::TB];
		w.fb   = w.y[sr_pkg::TB-1:sr_pkg::FRAC_BITS];
		w.r    = sr_pkg::R_ONE;
		nxt[sr_pkg::ST_SPLIT] = w;

		// exp2 of the fraction: one factor per stage
		rp = '0;
		for (int i = 0; i < sr_pkg::LOG_EXP_STEPS; i++) begin
			w = pipe_s[sr_pkg::ST_EXP0 + i - 1];
			if (w.fb[sr_pkg::LOG_EXP_STEPS - 1 - i]) begin
				rp  = sr_pkg::RP_W'(w.r) * sr_pkg::RP_W'(fac[i]);
				w.r = rp[sr_pkg::RP_W-2:sr_pkg::R_W-1];
			end
			nxt[sr_pkg::ST_EXP0 + i] = w;
		end

		// scale by the integer part, pick the power magnitude
		w    = pipe_s[sr_pkg::ST_SHIFT - 1];
		s    = (sr_pkg::YI_W + 1)'(w.yi) - (sr_pkg::YI_W + 1)'(sr_pkg::POW_BIAS);
		rsh  = ~s + 1'b1;
		psat = 1'b0;
		if (s >= sr_pkg::POW_SAT_SHIFT) begin
			pw   = sr_pkg::MAG_LIMIT;
			psat = 1'b1;
		end else if (!s[sr_pkg::YI_W]) begin
			pw = sr_pkg::PMAG_W'(w.r) << s[4:0];
		end else if (rsh >= (sr_pkg::YI_W + 1)'(sr_pkg::R_W)) begin
			pw = '0;
		end else begin
			pw = sr_pkg::PMAG_W'(w.r >> rsh[4:0]);
		end
		if (w.skip) begin
			w.pmag = sr_pkg::PMAG_W'(w.m);
		end else if (w.m_zero) begin
			w.pmag = w.e_zero ? sr_pkg::PMAG_W'(sr_pkg::ONE) : '0;
		end else begin
			w.pmag = pw;
			w.sat  = w.sat | psat;
		end
		nxt[sr_pkg::ST_SHIFT] = w;

		// gain times power, two partial products
		w     = pipe_s[sr_pkg::ST_MUL0 - 1];
		w.plo = sr_pkg::PLOP_W'(w.gmag) * sr_pkg::PLOP_W'(w.pmag[sr_pkg::PLO_W-1:0]);
		nxt[sr_pkg::ST_MUL0] = w;

		w     = pipe_s[sr_pkg::ST_MUL1 - 1];
		w.phi = sr_pkg::PHIP_W'(w.gmag)
			* sr_pkg::PHIP_W'(w.pmag[sr_pkg::PMAG_W-1:sr_pkg::PLO_W]);
		nxt[sr_pkg::ST_MUL1] = w;

		w   = pipe_s[sr_pkg::ST_SUM - 1];
		w.p = (sr_pkg::P_W'(w.phi) << sr_pkg::PLO_W) + sr_pkg::P_W'(w.plo);
		nxt[sr_pkg::ST_SUM] = w;

		// quotient overflow check and divider seed
		w      = pipe_s[sr_pkg::ST_OVF - 1];
		w.rem  = sr_pkg::GMAX_W'(w.p[sr_pkg::P_W-1:sr_pkg::PMAG_W]);
		w.ovf  = (w.rem >= cfg.max_cond);
		w.q    = '0;
		w.wneg = w.pneg ^ w.gneg;
		nxt[sr_pkg::ST_OVF] = w;

		// restoring division by Gmax, one quotient bit per stage
		for (int j = 0; j < sr_pkg::PMAG_W; j++) begin
			w     = pipe_s[sr_pkg::ST_DIV0 + j - 1];
			trial = {w.rem, w.p[sr_pkg::PMAG_W - 1 - j]};
			if (trial >= {1'b0, cfg.max_cond}) begin
				trial = trial - {1'b0, cfg.max_cond};
				w.q   = {w.q[sr_pkg::PMAG_W-2:0], 1'b1};
			end else begin
				w.q   = {w.q[sr_pkg::PMAG_W-2:0], 1'b0};
			end
			w.rem = trial[sr_pkg::GMAX_W-1:0];
			nxt[sr_pkg::ST_DIV0 + j] = w;
		end

		// work point
		w      = pipe_s[sr_pkg::ST_WSEL - 1];
		w.wmag = w.ovf ? sr_pkg::MAG_LIMIT : w.q;
		w.sat  = w.sat | w.ovf;
		w.pos  = (w.wmag != '0) && !w.wneg;
		nxt[sr_pkg::ST_WSEL] = w;

		// fraction operands
		w = pipe_s[sr_pkg::ST_FSET - 1];
		if (w.pos) begin
			w.fr  = sr_pkg::DEN_W'(w.wmag);
			w.den = sr_pkg::DEN_W'(sr_pkg::ONE - eta) + sr_pkg::DEN_W'(w.wmag);
		end else begin
			w.fr  = sr_pkg::DEN_W'(eta);
			w.den = sr_pkg::DEN_W'(eta) + sr_pkg::DEN_W'(w.wmag);
		end
		nxt[sr_pkg::ST_FSET] = w;

		// integer bit of the fraction
		w = pipe_s[sr_pkg::ST_F0 - 1];
		if (w.fr >= w.den) begin
			w.fr = w.fr - w.den;
			w.t  = sr_pkg::T_W'(1);
		end else begin
			w.t  = '0;
		end
		nxt[sr_pkg::ST_F0] = w;

		// fraction bits, one per stage
		for (int i = 0; i < sr_pkg::FRAC_BITS; i++) begin
			w   = pipe_s[sr_pkg::ST_FSTEP0 + i - 1];
			fr2 = {w.fr, 1'b0};
			if (fr2 >= {1'b0, w.den}) begin
				fr2 = fr2 - {1'b0, w.den};
				w.t = {w.t[sr_pkg::T_W-2:0], 1'b1};
			end else begin
				w.t = {w.t[sr_pkg::T_W-2:0], 1'b0};
			end
			w.fr = fr2[sr_pkg::DEN_W-1:0];
			nxt[sr_pkg::ST_FSTEP0 + i] = w;
		end

		// rectifier level in Q.F
		w = pipe_s[sr_pkg::ST_G - 1];
		if (w.pos) begin
			gp   = sr_pkg::GP_W'(sr_pkg::ONE - eta) * sr_pkg::GP_W'(w.t);
			w.gv = eta + gp[sr_pkg::FRAC_BITS + sr_pkg::T_W - 1:sr_pkg::FRAC_BITS];
		end else begin
			gp   = sr_pkg::GP_W'(eta) * sr_pkg::GP_W'(w.t);
			w.gv = gp[sr_pkg::FRAC_BITS + sr_pkg::T_W - 1:sr_pkg::FRAC_BITS];
		end
		nxt[sr_pkg::ST_G] = w;

		// output: scale by Gmax for the nonlinear kind
		w = pipe_s[sr_pkg::ST_OUT - 1];
		cp = sr_pkg::CP_W'(cfg.max_cond) * sr_pkg::CP_W'(w.gv);
		if (w.kind == sr_pkg::KIND_NONLIN) begin
			if (cfg.max_cond == '0) begin
				w.res = '0;
				w.sat = 1'b0;
			end else begin
				w.res = sr_pkg::COND_W'(cp[sr_pkg::CP_W-1:sr_pkg::FRAC_BITS]);
			end
		end else begin
			w.sat = 1'b0;
		end
		nxt[sr_pkg::ST_OUT] = w;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[sr_pkg::NSTAGE-2:0], item_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < sr_pkg::NSTAGE; k++) pipe_s[k] <= nxt[k];
		end
	end

endmodule
